FILE: rtl/frlc_pkg.sv
// Shared types, codes and constants of the file recipe lookup classifier.
`default_nettype none

package frlc_pkg;

	// Default recipe table depth
	localparam int TABLE_DEPTH_DEF = 1024;

	// Beat layout widths
	localparam int FID_W   = 32;
	localparam int CHK_W   = 20;
	localparam int SIZE_W  = 40;
	localparam int CIDX_W  = 3;
	localparam int VERD_W  = 3;
	localparam int TIER_W  = 4;
	localparam int CVAL_W  = 32;
	localparam int PCT_W   = 7;
	localparam int PROD_W  = 27;
	localparam int NUM_TIERS = 8;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 64;
	localparam int ENTRY_W = FID_W + CHK_W + SIZE_W;

	// Input beat field offsets
	localparam int IN_FID_LO  = 0;
	localparam int IN_CHK_LO  = IN_FID_LO + FID_W;
	localparam int IN_SIZE_LO = IN_CHK_LO + CHK_W;
	localparam int IN_CIDX_LO = IN_SIZE_LO + SIZE_W;

	// Output beat field offsets
	localparam int OUT_VERD_LO = 0;
	localparam int OUT_TOT_LO  = OUT_VERD_LO + VERD_W;
	localparam int OUT_TIER_LO = OUT_TOT_LO + CHK_W;
	localparam int OUT_CVAL_LO = OUT_TIER_LO + TIER_W;
	localparam int OUT_USED_W  = OUT_CVAL_LO + CVAL_W;

	// Action carried in tuser
	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	// Verdict codes
	localparam logic [VERD_W-1:0] VERD_NOT_FOUND = 3'd0;
	localparam logic [VERD_W-1:0] VERD_WHOLE     = 3'd1;
	localparam logic [VERD_W-1:0] VERD_PARTIAL   = 3'd2;
	localparam logic [VERD_W-1:0] VERD_MIGRATE   = 3'd3;
	localparam logic [VERD_W-1:0] VERD_FULL      = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_MIG_EN = 2'd0;
	localparam logic [1:0] CFG_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_PCT    = 2'd2;

	localparam logic [PCT_W-1:0] PCT_RESET = 7'd60;
	localparam int CFG_DATA_W = SIZE_W;

	// Tier thresholds in hundredths, tier 0 first
	localparam logic [PCT_W-1:0] TIER_PCT [NUM_TIERS] = '{
		7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95
	};

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic load;
		logic init;
		logic step;
		logic mul;
		logic fin;
		logic resp_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic hit;
		logic range_empty;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/frlc_ctrl.sv
// Sequencing state machine of the file recipe lookup classifier.
`default_nettype none

module frlc_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  [1:0]              s_tuser,
	output logic                    m_tvalid,
	input  wire                     m_tready,
	input  frlc_pkg::status_t       status,
	output frlc_pkg::cmd_t          cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOAD  = 7'b0000010,
		ST_START = 7'b0000100,
		ST_PROBE = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	frlc_pkg::action_t act;

	assign act      = frlc_pkg::action_t'(s_tuser);
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					case (act)
						frlc_pkg::ACT_LOAD:  state_d = ST_LOAD;
						frlc_pkg::ACT_QUERY: state_d = status.empty ? ST_RESP : ST_START;
						default:             state_d = ST_RESP;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_RESP;
			end
			ST_START: begin
				cmd.init = 1'b1;
				state_d  = ST_PROBE;
			end
			ST_PROBE: begin
				cmd.step = 1'b1;
				if (status.hit) begin
					state_d = ST_MUL;
				end else if (status.range_empty) begin
					state_d = ST_RESP;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || m_tready) begin
					cmd.resp_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.resp_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/frlc_dp.sv
// Datapath of the file recipe lookup classifier: table, search, ratio tests, counters.
`default_nettype none

module frlc_dp #(
	parameter int TABLE_DEPTH = frlc_pkg::TABLE_DEPTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [frlc_pkg::IN_DATA_W-1:0]       in_data,
	input  wire  [1:0]                           in_user,
	input  wire                                  cfg_valid,
	input  wire  [1:0]                           cfg_index,
	input  wire  [frlc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  frlc_pkg::cmd_t                       cmd,
	output frlc_pkg::status_t                    status,
	output logic [frlc_pkg::OUT_DATA_W-1:0]      out_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int FW = frlc_pkg::FID_W;
	localparam int KW = frlc_pkg::CHK_W;
	localparam int SW = frlc_pkg::SIZE_W;
	localparam int PW = frlc_pkg::PROD_W;
	localparam int NT = frlc_pkg::NUM_TIERS;

	// Recipe table: {file id, chunks, size}
	logic [frlc_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [frlc_pkg::ENTRY_W-1:0] rd_q;
	logic [AW-1:0]                rd_addr;

	// Configuration
	logic                         mig_en_q;
	logic [SW-1:0]                limit_q;
	logic [frlc_pkg::PCT_W-1:0]   pct_q;

	// Captured item
	logic [FW-1:0]                fid_q;
	logic [KW-1:0]                chunks_q;
	logic [SW-1:0]                size_q;

	// Search state
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                lo_q, hi_q, lo_n, hi_n;
	logic [AW-1:0]                mid_q;
	logic [CW:0]                  mid_sum;
	logic [FW-1:0]                rd_fid;
	logic [KW-1:0]                rd_chk;
	logic [SW-1:0]                rd_size;

	// Evaluation
	logic [KW-1:0]                tot_q;
	logic                         size_ok_q;
	logic [PW-1:0]                shared100_q, thr_q;
	logic [PW-1:0]                tier_prod_q [NT];
	logic [NT-1:0]                tier_pass;
	logic                         tot_zero, mig;
	logic [frlc_pkg::TIER_W-1:0]  tier_cnt;

	// Counters and result
	logic [frlc_pkg::CVAL_W-1:0]  cnt_q [NT];
	logic [frlc_pkg::VERD_W-1:0]  verd_q;
	logic [KW-1:0]                total_q;
	logic [frlc_pkg::TIER_W-1:0]  tiers_q;
	logic [frlc_pkg::CVAL_W-1:0]  cval_q;
	logic [frlc_pkg::OUT_DATA_W-1:0] out_q;

	assign rd_fid  = rd_q[frlc_pkg::ENTRY_W-1 -: FW];
	assign rd_chk  = rd_q[SW +: KW];
	assign rd_size = rd_q[SW-1:0];

	// Next search bounds and probe address
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (cmd.init) begin
			lo_n = '0;
			hi_n = count_q;
		end else if (rd_fid < fid_q) begin
			lo_n = CW'(mid_q) + CW'(1);
		end else begin
			hi_n = CW'(mid_q);
		end
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n} - (CW + 1)'(1);
		rd_addr = mid_sum[AW:1];
	end

	assign status.empty       = (count_q == '0);
	assign status.hit         = (rd_fid == fid_q);
	assign status.range_empty = (lo_n >= hi_n);

	// Table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.load && count_q != CW'(TABLE_DEPTH)) begin
			mem[count_q[AW-1:0]] <= {fid_q, chunks_q, size_q};
		end
		rd_q <= mem[rd_addr];
	end

	// Ratio tests on the registered products; a whole match is never a candidate
	always_comb begin
		tot_zero = (tot_q == '0);
		mig      = mig_en_q && size_ok_q && !tot_zero && (tot_q != chunks_q) &&
			(shared100_q >= thr_q);
		tier_cnt = '0;
		for (int t = 0; t < NT; t++) begin
			tier_pass[t] = mig && (shared100_q >= tier_prod_q[t]);
			tier_cnt     = tier_cnt + frlc_pkg::TIER_W'(tier_pass[t]);
		end
	end

	// Hold configuration, counters and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mig_en_q <= 1'b0;
			limit_q  <= '0;
			pct_q    <= frlc_pkg::PCT_RESET;
			count_q  <= '0;
			for (int t = 0; t < NT; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					frlc_pkg::CFG_MIG_EN: mig_en_q <= cfg_data[0];
					frlc_pkg::CFG_LIMIT:  limit_q  <= cfg_data;
					frlc_pkg::CFG_PCT:    pct_q    <= cfg_data[frlc_pkg::PCT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && count_q != CW'(TABLE_DEPTH)) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.fin) begin
				for (int t = 0; t < NT; t++) begin
					if (tier_pass[t]) begin
						cnt_q[t] <= cnt_q[t] + 32'd1;
					end
				end
			end
		end
	end

	// Capture item, walk the search, form the result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fid_q    <= in_data[frlc_pkg::IN_FID_LO +: FW];
			chunks_q <= in_data[frlc_pkg::IN_CHK_LO +: KW];
			size_q   <= in_data[frlc_pkg::IN_SIZE_LO +: SW];
			verd_q   <= frlc_pkg::VERD_NOT_FOUND;
			total_q  <= '0;
			tiers_q  <= '0;
			cval_q   <= (frlc_pkg::action_t'(in_user) == frlc_pkg::ACT_READ) ?
				cnt_q[in_data[frlc_pkg::IN_CIDX_LO +: frlc_pkg::CIDX_W]] : '0;
		end
		if (cmd.load && count_q == CW'(TABLE_DEPTH)) begin
			verd_q <= frlc_pkg::VERD_FULL;
		end
		if (cmd.init || (cmd.step && !status.hit)) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= rd_addr;
		end
		if (cmd.step && status.hit) begin
			tot_q     <= rd_chk;
			total_q   <= rd_chk;
			size_ok_q <= (rd_size >= limit_q);
		end
		if (cmd.mul) begin
			shared100_q <= PW'(chunks_q) * PW'(100);
			thr_q       <= PW'(pct_q) * PW'(tot_q);
			for (int t = 0; t < NT; t++) begin
				tier_prod_q[t] <= PW'(frlc_pkg::TIER_PCT[t]) * PW'(tot_q);
			end
		end
		if (cmd.fin) begin
			if (tot_q == chunks_q) begin
				verd_q <= frlc_pkg::VERD_WHOLE;
			end else if (mig) begin
				verd_q  <= frlc_pkg::VERD_MIGRATE;
				tiers_q <= tier_cnt;
			end else begin
				verd_q <= frlc_pkg::VERD_PARTIAL;
			end
		end
		if (cmd.resp_load) begin
			out_q <= frlc_pkg::OUT_DATA_W'({cval_q, tiers_q, total_q, verd_q});
		end
	end

	assign out_data = out_q;

	// A whole match never counts toward a tier
	a_whole_no_tier: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && tot_q == chunks_q) |=> (tiers_q == '0))
		else $error("tier count set on a whole match");

	// The fill count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// A probe always runs over a nonempty range
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (lo_q < hi_q))
		else $error("probe on an empty search range");

	// The first and last tier counters move only when a query finishes
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.fin |=> ($stable(cnt_q[0]) && $stable(cnt_q[NT-1])))
		else $error("tier counter changed outside query finish");

endmodule

`default_nettype wire

FILE: rtl/file_recipe_lookup_classifier.sv
// Top level of the file recipe lookup classifier.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready   | tuser action, tdata item fields
//  m_       | out       | m_tvalid/m_tready   | tdata verdict, totals, tiers, counter
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item at a time. A load passes through LOAD and RESP; a counter read, a no-op or
// a query on an empty table goes straight to RESP; a query runs START and then its
// binary search probes, at most floor(log2(entries)) + 1 of them, and on a hit goes on
// through MUL and FIN before RESP. Each probe is one registered read of the table
// memory. Reset clears the fill count and the tier counters and returns the
// configuration to its reset values; the table itself needs no clearing pass. A new
// beat is taken while the previous result waits in the output register; a stall on m_
// only holds the block once the next result is ready.
`default_nettype none

module file_recipe_lookup_classifier #(
	parameter int TABLE_DEPTH = frlc_pkg::TABLE_DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// tuser: action[1:0]
	input  wire  [1:0]                         s_tuser,
	// tdata: file_id[31:0], chunk_count[51:32], file_size[91:52], counter_index[94:92]
	input  wire  [frlc_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// tdata: verdict[2:0], total_chunks[22:3], tier_reached[26:23], counter_value[58:27]
	output logic [frlc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [1:0]                         cfg_index,
	input  wire  [frlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	frlc_pkg::cmd_t    cmd;
	frlc_pkg::status_t status;

	assign cfg_ready = 1'b1;

	frlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	frlc_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/file_recipe_lookup_classifier_tb.sv
// Self-checking testbench for the file recipe lookup classifier.
`timescale 1ns / 100ps

module file_recipe_lookup_classifier_tb;

	localparam int CLK_PERIOD     = 10;
	localparam int DEPTH          = frlc_pkg::TABLE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int LONG_HOLD      = 250;
	localparam int SEGMENT_ITEMS  = 280;
	localparam int NUM_SEGMENTS   = 6;
	localparam logic [frlc_pkg::CHK_W-1:0]  CHK_MAX  = '1;
	localparam logic [frlc_pkg::SIZE_W-1:0] SIZE_MAX = '1;

	// One expected result beat, field by field
	typedef struct packed {
		logic [frlc_pkg::VERD_W-1:0] verdict;
		logic [frlc_pkg::CHK_W-1:0]  total;
		logic [frlc_pkg::TIER_W-1:0] tiers;
		logic [frlc_pkg::CVAL_W-1:0] cval;
	} verdict_beat_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [1:0]                      s_tuser   = frlc_pkg::ACT_NOP;
	logic [frlc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [frlc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [1:0]                      cfg_index = frlc_pkg::CFG_MIG_EN;
	logic [frlc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// Shadow copy of the recipe table, tier counters and registers
	logic [frlc_pkg::FID_W-1:0]  recipe_id     [DEPTH];
	logic [frlc_pkg::CHK_W-1:0]  recipe_chunks [DEPTH];
	logic [frlc_pkg::SIZE_W-1:0] recipe_size   [DEPTH];
	int                          recipe_count = 0;
	logic [frlc_pkg::CVAL_W-1:0] tier_hits [frlc_pkg::NUM_TIERS] = '{default: '0};
	logic                        mig_en     = 1'b0;
	logic [frlc_pkg::SIZE_W-1:0] big_limit  = '0;
	logic [frlc_pkg::PCT_W-1:0]  thresh_pct = frlc_pkg::PCT_RESET;

	verdict_beat_t               pending_verdicts [$];
	logic [frlc_pkg::FID_W-1:0]  top_id = '0;
	int                          mismatches = 0;
	int                          quiet_cycles = 0;
	int                          long_hold = 0;
	int                          rx_gap = 0;
	bit                          tx_idling = 1'b1;
	bit                          rx_idling = 1'b1;

	file_recipe_lookup_classifier uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Exact ratio test in hundredths; a zero total never passes
	function automatic bit ratio_ok(logic [frlc_pkg::CHK_W-1:0] shared,
		logic [frlc_pkg::CHK_W-1:0] total, logic [frlc_pkg::PCT_W-1:0] pct);
		logic [63:0] lhs;
		logic [63:0] rhs;
		lhs = 64'(shared) * 64'd100;
		rhs = 64'(pct) * 64'(total);
		return (total != 0) && (lhs >= rhs);
	endfunction

	// Work out the result of one accepted beat and advance the shadow state
	function automatic verdict_beat_t classify_item(frlc_pkg::action_t act,
		logic [frlc_pkg::FID_W-1:0] fid, logic [frlc_pkg::CHK_W-1:0] chunks,
		logic [frlc_pkg::SIZE_W-1:0] fsize, logic [frlc_pkg::CIDX_W-1:0] cidx);
		verdict_beat_t res;
		int lo;
		int hi;
		int mid;
		int t;
		bit found;
		res = '0;
		case (act)
			frlc_pkg::ACT_LOAD: begin
				if (recipe_count >= DEPTH) begin
					res.verdict = frlc_pkg::VERD_FULL;
				end else begin
					recipe_id[recipe_count]     = fid;
					recipe_chunks[recipe_count] = chunks;
					recipe_size[recipe_count]   = fsize;
					recipe_count++;
				end
			end
			frlc_pkg::ACT_QUERY: begin
				lo = 0;
				hi = recipe_count - 1;
				found = 1'b0;
				while (!found && lo <= hi) begin
					mid = (lo + hi) / 2;
					if (recipe_id[mid] == fid) begin
						found = 1'b1;
						res.total = recipe_chunks[mid];
						res.verdict = frlc_pkg::VERD_PARTIAL;
						if (res.total == chunks) begin
							res.verdict = frlc_pkg::VERD_WHOLE;
						end else if (mig_en && recipe_size[mid] >= big_limit &&
							ratio_ok(chunks, res.total, thresh_pct)) begin
							res.verdict = frlc_pkg::VERD_MIGRATE;
							// tiers rise monotonically, so passing one implies all below
							for (t = 0; t < frlc_pkg::NUM_TIERS; t++) begin
								if (ratio_ok(chunks, res.total, frlc_pkg::TIER_PCT[t])) begin
									tier_hits[t] = tier_hits[t] + 1'b1;
									res.tiers = res.tiers + 1'b1;
								end
							end
						end
					end else if (recipe_id[mid] < fid) begin
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
			end
			frlc_pkg::ACT_READ: begin
				res.cval = tier_hits[cidx];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic logic [frlc_pkg::SIZE_W-1:0] rand_size();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SIZE_MAX;
			2: return big_limit;
			3: return big_limit - 1'b1;
			default: return frlc_pkg::SIZE_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic [frlc_pkg::CHK_W-1:0] rand_chunks();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CHK_MAX;
			2: return frlc_pkg::CHK_W'($urandom_range(1, 100));
			default: return frlc_pkg::CHK_W'($urandom);
		endcase
	endfunction

	// Pick a shared count around the interesting points of a recipe's total
	function automatic logic [frlc_pkg::CHK_W-1:0] pick_shared(
		logic [frlc_pkg::CHK_W-1:0] total);
		logic [63:0] bound;
		logic [frlc_pkg::PCT_W-1:0] pct;
		case ($urandom_range(0, 7))
			0: return total;
			1: return '0;
			2: return frlc_pkg::CHK_W'($urandom_range(0, total));
			3, 4: begin
				pct = ($urandom_range(0, 2) == 0) ? thresh_pct
					: frlc_pkg::TIER_PCT[$urandom_range(0, frlc_pkg::NUM_TIERS - 1)];
				bound = (64'(total) * 64'(pct) + 64'd99) / 64'd100;
				bound = bound + 64'($urandom_range(0, 2)) - 64'd1;
				return (bound > 64'(CHK_MAX)) ? CHK_MAX : frlc_pkg::CHK_W'(bound);
			end
			5: return frlc_pkg::CHK_W'($urandom_range(total, CHK_MAX));
			default: return frlc_pkg::CHK_W'($urandom);
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one beat, hold it until accepted, then maybe idle
	task automatic send_item(input frlc_pkg::action_t act,
		input logic [frlc_pkg::FID_W-1:0] fid, input logic [frlc_pkg::CHK_W-1:0] chunks,
		input logic [frlc_pkg::SIZE_W-1:0] fsize, input logic [frlc_pkg::CIDX_W-1:0] cidx);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {1'b0, cidx, fsize, chunks, fid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_verdicts.push_back(classify_item(act, fid, chunks, fsize, cidx));
		if (tx_idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every result, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back; junk above the used bits must be ignored
	task automatic write_config(input logic en, input logic [frlc_pkg::SIZE_W-1:0] limit,
		input logic [frlc_pkg::PCT_W-1:0] pct);
		logic [1:0] idx [3];
		logic [frlc_pkg::CFG_DATA_W-1:0] word [3];
		logic [frlc_pkg::CFG_DATA_W-1:0] junk;
		int i;
		junk = frlc_pkg::CFG_DATA_W'({$urandom, $urandom});
		idx = '{frlc_pkg::CFG_MIG_EN, frlc_pkg::CFG_LIMIT, frlc_pkg::CFG_PCT};
		word[0] = {junk[frlc_pkg::CFG_DATA_W-1:1], en};
		word[1] = limit;
		word[2] = {junk[frlc_pkg::CFG_DATA_W-1:frlc_pkg::PCT_W], pct};
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= word[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		mig_en = en;
		big_limit = limit;
		thresh_pct = pct;
	endtask

	// Load the next recipe: ascending ids with gaps, now and then a repeat or a step back
	task automatic send_load();
		logic [frlc_pkg::FID_W-1:0] fid;
		logic [63:0] nxt;
		if (recipe_count >= DEPTH) begin
			fid = $urandom;
		end else if (recipe_count == DEPTH - 1) begin
			fid = '1;
		end else if ($urandom_range(0, 39) == 0 && top_id > 3) begin
			fid = top_id - frlc_pkg::FID_W'($urandom_range(0, 3));
		end else begin
			nxt = 64'(top_id) + 64'($urandom_range(1, 1 << 22));
			fid = (nxt > 64'h0_FFFF_FFFE) ? 32'hFFFF_FFFE : frlc_pkg::FID_W'(nxt);
		end
		if (fid > top_id) top_id = fid;
		send_item(frlc_pkg::ACT_LOAD, fid, rand_chunks(), rand_size(),
			frlc_pkg::CIDX_W'($urandom));
	endtask

	// Query mostly loaded ids, sometimes a neighbor or a random id
	task automatic send_query();
		int idx;
		logic [frlc_pkg::FID_W-1:0] fid;
		logic [frlc_pkg::CHK_W-1:0] shared;
		if (recipe_count > 0 && $urandom_range(0, 4) != 0) begin
			idx = $urandom_range(0, recipe_count - 1);
			fid = recipe_id[idx];
			shared = pick_shared(recipe_chunks[idx]);
		end else begin
			idx = (recipe_count > 0) ? $urandom_range(0, recipe_count - 1) : 0;
			fid = (recipe_count > 0 && $urandom_range(0, 1) == 0) ? recipe_id[idx] + 1'b1
				: frlc_pkg::FID_W'($urandom);
			shared = frlc_pkg::CHK_W'($urandom);
		end
		send_item(frlc_pkg::ACT_QUERY, fid, shared, rand_size(),
			frlc_pkg::CIDX_W'($urandom));
	endtask

	task automatic rand_item();
		int pick;
		int load_pct;
		pick = $urandom_range(0, 99);
		load_pct = (recipe_count < DEPTH) ? 60 : 10;
		if (pick < load_pct)
			send_load();
		else if (pick < 92)
			send_query();
		else if (pick < 98)
			send_item(frlc_pkg::ACT_READ, frlc_pkg::FID_W'($urandom),
				frlc_pkg::CHK_W'($urandom), rand_size(), frlc_pkg::CIDX_W'($urandom));
		else
			send_item(frlc_pkg::ACT_NOP, frlc_pkg::FID_W'($urandom),
				frlc_pkg::CHK_W'($urandom), rand_size(), frlc_pkg::CIDX_W'($urandom));
	endtask

	// Query, counter read and no-op on an empty table with reset settings
	task automatic test_empty_table();
		send_item(frlc_pkg::ACT_QUERY, '0, '0, '0, '0);
		send_item(frlc_pkg::ACT_READ, '1, CHK_MAX, SIZE_MAX, frlc_pkg::CIDX_W'(7));
		send_item(frlc_pkg::ACT_NOP, '1, CHK_MAX, SIZE_MAX, '1);
	endtask

	// Hand-picked loads and queries over each verdict and threshold corner
	task automatic test_directed_lookup();
		wait_idle();
		write_config(1'b1, '0, frlc_pkg::PCT_RESET);
		send_item(frlc_pkg::ACT_LOAD, '0, '0, '0, '0);
		send_item(frlc_pkg::ACT_LOAD, frlc_pkg::FID_W'(5), CHK_MAX, SIZE_MAX, '1);
		send_item(frlc_pkg::ACT_LOAD, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(100),
			frlc_pkg::SIZE_W'(1000), '0);
		// repeated id, then an id out of order
		send_item(frlc_pkg::ACT_LOAD, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(50),
			frlc_pkg::SIZE_W'(7), '0);
		send_item(frlc_pkg::ACT_LOAD, frlc_pkg::FID_W'(3), frlc_pkg::CHK_W'(40),
			frlc_pkg::SIZE_W'(40), '0);
		top_id = frlc_pkg::FID_W'(9);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(5), CHK_MAX, '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(5), CHK_MAX - 1'b1, '0, '0);
		// zero total never passes the ratio
		send_item(frlc_pkg::ACT_QUERY, '0, frlc_pkg::CHK_W'(5), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(60), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(59), '0, '0);
		// shared above the total
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(200), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(3), frlc_pkg::CHK_W'(40), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(7), frlc_pkg::CHK_W'(1), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, '1, '0, '0, '0);
		send_item(frlc_pkg::ACT_READ, '0, '0, '0, '0);
		send_item(frlc_pkg::ACT_READ, '0, '0, '0, frlc_pkg::CIDX_W'(7));
		// threshold above one hundred
		wait_idle();
		write_config(1'b1, '0, '1);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(127), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(126), '0, '0);
		// migration off: partial stays partial, equal stays whole
		wait_idle();
		write_config(1'b0, '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(99), '0, '0);
		send_item(frlc_pkg::ACT_QUERY, frlc_pkg::FID_W'(9), frlc_pkg::CHK_W'(100), '0, '0);
	endtask

	// Hold the result side off while the sender keeps offering beats
	task automatic test_backpressure();
		tx_idling = 1'b0;
		long_hold = LONG_HOLD;
		repeat (30) rand_item();
		wait_idle();
	endtask

	// One random segment under its own register setting
	task automatic test_random_segment(input int seg);
		wait_idle();
		case (seg)
			0: write_config(1'b0, frlc_pkg::SIZE_W'({$urandom, $urandom}),
				frlc_pkg::PCT_RESET);
			1: write_config(1'b1, '0, '0);
			2: write_config(1'b1, SIZE_MAX, frlc_pkg::PCT_W'(100));
			3: write_config(1'b1, frlc_pkg::SIZE_W'({$urandom, $urandom}),
				frlc_pkg::PCT_W'($urandom_range(0, 127)));
			4: write_config(1'b1, frlc_pkg::SIZE_W'($urandom_range(0, 1000000)),
				frlc_pkg::PCT_W'($urandom_range(101, 127)));
			default: write_config(1'b1,
				frlc_pkg::SIZE_W'({$urandom, $urandom}) >> $urandom_range(0, 39),
				frlc_pkg::PCT_W'($urandom_range(60, 95)));
		endcase
		tx_idling = (seg < NUM_SEGMENTS - 1) && ($urandom_range(0, 3) != 0);
		rx_idling = (seg < NUM_SEGMENTS - 1) && ($urandom_range(0, 3) != 0);
		repeat (SEGMENT_ITEMS) rand_item();
	endtask

	// Fill the table to the top, then refused loads and lookups on a full table
	task automatic test_table_full();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		while (recipe_count < DEPTH) send_load();
		repeat (4) send_load();
		repeat (60) rand_item();
	endtask

	// Drive the result side ready: long hold, random stall bursts, or always ready
	always @(posedge clk) begin
		if (long_hold > 0) begin
			m_tready <= 1'b0;
			long_hold <= long_hold - 1;
		end else if (!rx_idling) begin
			m_tready <= 1'b1;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap <= rx_gap - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_gap <= $urandom_range(0, 18);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result beat against the oldest expectation
	always @(posedge clk) begin
		verdict_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none got %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("verdict", 64'(want.verdict),
					64'(m_tdata[frlc_pkg::OUT_VERD_LO +: frlc_pkg::VERD_W]));
				check_field("total_chunks", 64'(want.total),
					64'(m_tdata[frlc_pkg::OUT_TOT_LO +: frlc_pkg::CHK_W]));
				check_field("tier_reached", 64'(want.tiers),
					64'(m_tdata[frlc_pkg::OUT_TIER_LO +: frlc_pkg::TIER_W]));
				check_field("counter_value", 64'(want.cval),
					64'(m_tdata[frlc_pkg::OUT_CVAL_LO +: frlc_pkg::CVAL_W]));
			end
		end
	end

	// Count cycles with no beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int seg;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_lookup();
		test_backpressure();
		for (seg = 0; seg < NUM_SEGMENTS; seg++)
			test_random_segment(seg);
		test_table_full();
		wait_idle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
